// File: rtl/core/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants of the TCP response classifier.
// ----------------------------------------------------------------------------
package trc_pkg;

  // Byte position within a frame; it saturates at its all-ones value.
  typedef logic [6:0] pos_t;
  // Frame length, one bit wider than a position.
  typedef logic [7:0] len_t;

  localparam pos_t POS_MAX       = 7'd127;
  localparam pos_t POS_ETYPE_HI  = 7'd12;
  localparam pos_t POS_ETYPE_LO  = 7'd13;
  localparam pos_t POS_IHL       = 7'd14;
  localparam pos_t POS_PROTO     = 7'd23;
  localparam pos_t POS_SRC_FIRST = 7'd26;
  localparam pos_t POS_SRC_LAST  = 7'd29;
  localparam pos_t POS_DST_FIRST = 7'd30;
  localparam pos_t POS_DST_LAST  = 7'd33;
  localparam pos_t ETH_LEN       = 7'd14;

  // Offsets inside the TCP header.
  localparam pos_t TCP_SPORT_HI  = 7'd0;
  localparam pos_t TCP_SPORT_LO  = 7'd1;
  localparam pos_t TCP_DPORT_HI  = 7'd2;
  localparam pos_t TCP_DPORT_LO  = 7'd3;
  localparam pos_t TCP_FLAGS     = 7'd13;

  localparam len_t TCP_LEN       = 8'd20;
  localparam len_t MIN_FRAME_LEN = 8'd54;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam int unsigned FLAG_SYN_BIT = 1;
  localparam int unsigned FLAG_RST_BIT = 2;
  localparam int unsigned FLAG_ACK_BIT = 4;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 4;
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_LOCAL_IP  = 2'd0;
  localparam reg_idx_t REG_PORT_LOW  = 2'd1;
  localparam reg_idx_t REG_PORT_HIGH = 2'd2;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [7:0]  flags;
  } hdr_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] responder_ip;
    logic [15:0] responder_port;
    logic        port_open;
  } result_t;

endpackage

// File: rtl/core/trc_in_if.sv
// ----------------------------------------------------------------------------
// trc_in_if
// Byte stream channel carrying frame bytes with a last-byte mark.
// ----------------------------------------------------------------------------
interface trc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// File: rtl/core/trc_out_if.sv
// ----------------------------------------------------------------------------
// trc_out_if
// Result channel carrying one classification per frame.
// ----------------------------------------------------------------------------
interface trc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] responder_ip;
  logic [15:0] responder_port;
  logic        port_open;

  modport source (output valid, output accepted, output responder_ip,
                  output responder_port, output port_open, input ready);
  modport sink   (input valid, input accepted, input responder_ip,
                  input responder_port, input port_open, output ready);
endinterface

// File: rtl/core/trc_cfg_regs.sv
// ----------------------------------------------------------------------------
// trc_cfg_regs
// APB register bank holding the local address and the accepted port range.
// ----------------------------------------------------------------------------
module trc_cfg_regs
  import trc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LOCAL_IP:  cfg_nxt.local_ip  = pwdata;
        REG_PORT_LOW:  cfg_nxt.port_low  = pwdata[15:0];
        REG_PORT_HIGH: cfg_nxt.port_high = pwdata[15:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOCAL_IP:  prdata = cfg_r.local_ip;
      REG_PORT_LOW:  prdata = {16'd0, cfg_r.port_low};
      REG_PORT_HIGH: prdata = {16'd0, cfg_r.port_high};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_ip  <= 32'd0;
      cfg_r.port_low  <= 16'd0;
      cfg_r.port_high <= 16'hFFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/core/trc_hdr_capture.sv
// ----------------------------------------------------------------------------
// trc_hdr_capture
// Byte position counter and capture of the Ethernet, IPv4 and TCP fields.
// ----------------------------------------------------------------------------
module trc_hdr_capture
  import trc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output pos_t       pos_o,
  output hdr_t       hdr_o
);

  pos_t pos_r;
  pos_t pos_nxt;
  hdr_t hdr_r;
  hdr_t hdr_nxt;
  hdr_t upd;
  pos_t tcp_at;

  // The header length captured on this very byte already moves the TCP
  // header, so the offset is taken from the updated value.
  always_comb begin
    upd = hdr_r;
    if (pos_r == POS_ETYPE_HI) upd.ether_type[15:8] = byte_i;
    if (pos_r == POS_ETYPE_LO) upd.ether_type[7:0]  = byte_i;
    if (pos_r == POS_IHL)      upd.ihl              = byte_i[3:0];
    if (pos_r == POS_PROTO)    upd.proto            = byte_i;
    if (pos_r >= POS_SRC_FIRST && pos_r <= POS_SRC_LAST)
      upd.src_addr = {hdr_r.src_addr[23:0], byte_i};
    if (pos_r >= POS_DST_FIRST && pos_r <= POS_DST_LAST)
      upd.dst_addr = {hdr_r.dst_addr[23:0], byte_i};

    tcp_at = ETH_LEN + pos_t'({upd.ihl, 2'b00});
    if (pos_r == tcp_at + TCP_SPORT_HI || pos_r == tcp_at + TCP_SPORT_LO)
      upd.tcp_sport = {hdr_r.tcp_sport[7:0], byte_i};
    if (pos_r == tcp_at + TCP_DPORT_HI || pos_r == tcp_at + TCP_DPORT_LO)
      upd.tcp_dport = {hdr_r.tcp_dport[7:0], byte_i};
    if (pos_r == tcp_at + TCP_FLAGS)
      upd.flags = byte_i;
  end

  always_comb begin
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    if (adv) begin
      if (last_i) begin
        pos_nxt = '0;
        hdr_nxt = '0;
      end else begin
        hdr_nxt = upd;
        if (pos_r != POS_MAX) pos_nxt = pos_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hdr_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  assign pos_o = pos_r;
  assign hdr_o = upd;

endmodule

// File: rtl/core/trc_classify.sv
// ----------------------------------------------------------------------------
// trc_classify
// Judges a complete frame and forms its result item.
// ----------------------------------------------------------------------------
module trc_classify
  import trc_pkg::*;
(
  input  pos_t    pos_i,
  input  hdr_t    hdr_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  len_t len;
  len_t tcp_end;
  logic rst;
  logic synack;
  logic ok;

  always_comb begin
    len     = {1'b0, pos_i} + 8'd1;
    tcp_end = len_t'(ETH_LEN) + len_t'({hdr_i.ihl, 2'b00}) + TCP_LEN;
    rst     = hdr_i.flags[FLAG_RST_BIT];
    synack  = hdr_i.flags[FLAG_SYN_BIT] && hdr_i.flags[FLAG_ACK_BIT];

    ok = (len >= MIN_FRAME_LEN) &&
         (hdr_i.ether_type == ETHERTYPE_IPV4) &&
         (hdr_i.proto == PROTO_TCP) &&
         (hdr_i.dst_addr == cfg_i.local_ip) &&
         (len >= tcp_end) &&
         (hdr_i.tcp_dport >= cfg_i.port_low) &&
         (hdr_i.tcp_dport <= cfg_i.port_high) &&
         (rst || synack);

    res_o.accepted       = ok;
    res_o.responder_ip   = ok ? hdr_i.src_addr : 32'd0;
    res_o.responder_port = ok ? hdr_i.tcp_sport : 16'd0;
    // A reset flag wins over SYN+ACK and reports the port closed.
    res_o.port_open      = ok && !rst;
  end

endmodule

// File: rtl/core/tcp_response_classifier_core.sv
// ----------------------------------------------------------------------------
// tcp_response_classifier_core
// Parses Ethernet/IPv4/TCP headers from a byte stream and flags RST or
// SYN+ACK responses addressed to the local address and port range.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Payload
//   in_chan   in         valid/ready     frame_byte[7:0], last_byte
//   out_chan  out        valid/ready     accepted, responder_ip[31:0],
//                                        responder_port[15:0], port_open
//   APB       in/out     psel/penable    local_ip, port_low, port_high
//
// One byte is accepted per cycle while the input register can advance. A byte
// is held in the input register and then folded into the captured header; the
// final byte of a frame has its result registered in the output register. A
// stalled result holds a final byte in the input register, and the input waits.
// Synchronous active-low reset clears the frame state and the registers.
module tcp_response_classifier_core
  import trc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  trc_in_if.sink                in_chan,
  trc_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       out_free;
  logic       out_valid_r;
  logic       out_valid_nxt;
  result_t    res_r;
  result_t    res;
  pos_t       pos;
  hdr_t       hdr;
  cfg_t       cfg;

  trc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  trc_hdr_capture u_capture (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s1_adv),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .pos_o  (pos),
    .hdr_o  (hdr)
  );

  trc_classify u_classify (
    .pos_i (pos),
    .hdr_i (hdr),
    .cfg_i (cfg),
    .res_o (res)
  );

  // Only a final byte needs room in the output register.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_adv        = s1_valid_r && (!s1_last_r || out_free);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_chan.valid && in_chan.ready) s1_valid_nxt = 1'b1;
    else if (s1_adv)                    s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r)  out_valid_nxt = 1'b1;
    else if (out_chan.ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.frame_byte;
      s1_last_r <= in_chan.last_byte;
    end
    if (s1_adv && s1_last_r) begin
      res_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.accepted       = res_r.accepted;
  assign out_chan.responder_ip   = res_r.responder_ip;
  assign out_chan.responder_port = res_r.responder_port;
  assign out_chan.port_open      = res_r.port_open;

endmodule

// File: verif/tcp_classifier_checker.sv
// ----------------------------------------------------------------------------
// tcp_classifier_checker
// Watches the byte and result channels and the register port, predicts one
// classification per frame and compares it with each result the block gives.
// ----------------------------------------------------------------------------
module tcp_classifier_checker
  import trc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  trc_in_if                     in_mon,
  trc_out_if                    out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  cfg_t    regs;
  hdr_t    hdr;
  pos_t    frame_pos;
  result_t expected_verdicts[$];

  task automatic log_failure(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected acc=%0b ip=%h port=%h open=%0b", $time, what,
               want.accepted, want.responder_ip, want.responder_port, want.port_open);
      $display("%0t %s: actual   acc=%0b ip=%h port=%h open=%0b", $time, what,
               got.accepted, got.responder_ip, got.responder_port, got.port_open);
    end
  endtask

  always @(posedge clk) begin : classify_frames
    int unsigned pos;
    int unsigned tcp_at;
    int unsigned rx_len;
    logic [7:0]  b;
    logic        ok;
    logic        open;
    result_t     want;
    result_t     got;
    if (!rst_n) begin
      regs = '{local_ip: 32'h0, port_low: 16'h0, port_high: 16'hFFFF};
      hdr = '0;
      frame_pos = '0;
      expected_verdicts.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
          REG_LOCAL_IP:  regs.local_ip = pwdata;
          REG_PORT_LOW:  regs.port_low = pwdata[15:0];
          REG_PORT_HIGH: regs.port_high = pwdata[15:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        b = in_mon.frame_byte;
        pos = frame_pos;
        if (pos == POS_ETYPE_HI) hdr.ether_type[15:8] = b;
        if (pos == POS_ETYPE_LO) hdr.ether_type[7:0] = b;
        if (pos == POS_IHL) hdr.ihl = b[3:0];
        if (pos == POS_PROTO) hdr.proto = b;
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) hdr.src_addr = {hdr.src_addr[23:0], b};
        if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) hdr.dst_addr = {hdr.dst_addr[23:0], b};

        // The TCP offset follows the header length as captured so far, so a
        // short header lets TCP fields land on top of IPv4 fields.
        tcp_at = int'(ETH_LEN) + 4 * int'(hdr.ihl);
        if (pos == tcp_at + TCP_SPORT_HI || pos == tcp_at + TCP_SPORT_LO)
          hdr.tcp_sport = {hdr.tcp_sport[7:0], b};
        if (pos == tcp_at + TCP_DPORT_HI || pos == tcp_at + TCP_DPORT_LO)
          hdr.tcp_dport = {hdr.tcp_dport[7:0], b};
        if (pos == tcp_at + TCP_FLAGS) hdr.flags = b;

        if (frame_pos != POS_MAX) frame_pos++;

        if (in_mon.last_byte) begin
          rx_len = pos + 1;
          ok = (rx_len >= MIN_FRAME_LEN) &&
               (hdr.ether_type == ETHERTYPE_IPV4) &&
               (hdr.proto == PROTO_TCP) &&
               (hdr.dst_addr == regs.local_ip) &&
               (rx_len >= tcp_at + TCP_LEN) &&
               (hdr.tcp_dport >= regs.port_low) &&
               (hdr.tcp_dport <= regs.port_high);
          // RST takes priority over SYN+ACK and reports the port closed.
          if (hdr.flags[FLAG_RST_BIT]) begin
            open = 1'b0;
          end else if (hdr.flags[FLAG_SYN_BIT] && hdr.flags[FLAG_ACK_BIT]) begin
            open = 1'b1;
          end else begin
            open = 1'b0;
            ok = 1'b0;
          end
          want.accepted       = ok;
          want.responder_ip   = ok ? hdr.src_addr : 32'h0;
          want.responder_port = ok ? hdr.tcp_sport : 16'h0;
          want.port_open      = ok && open;
          expected_verdicts.push_back(want);
          hdr = '0;
          frame_pos = '0;
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        got = '{accepted: out_mon.accepted, responder_ip: out_mon.responder_ip,
                responder_port: out_mon.responder_port, port_open: out_mon.port_open};
        if (expected_verdicts.size() == 0) begin
          log_failure("unexpected result", '0, got);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.accepted !== want.accepted ||
              got.responder_ip !== want.responder_ip ||
              got.responder_port !== want.responder_port ||
              got.port_open !== want.port_open)
            log_failure("result mismatch", want, got);
        end
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives Ethernet frames byte by byte into the TCP response classifier,
// reprograms its address and port range between phases and gives the verdict
// from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import trc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PARK_CYCLES   = 300;
  localparam int TARGET_BYTES  = 1250;
  localparam int PHASE_COUNT   = 6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] FL_SYN = 8'd1 << FLAG_SYN_BIT;
  localparam logic [7:0] FL_RST = 8'd1 << FLAG_RST_BIT;
  localparam logic [7:0] FL_ACK = 8'd1 << FLAG_ACK_BIT;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  logic        steady = 1'b0;
  logic        park_out = 1'b0;
  logic [31:0] cur_ip;
  logic [15:0] cur_low;
  logic [15:0] cur_high;
  logic [7:0]  frame_buf[$];
  int          bytes_sent;
  int          cycle_count;

  trc_in_if  in_chan();
  trc_out_if out_chan();

  tcp_response_classifier_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tcp_classifier_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: a random stall before each item outside steady phases, and one
  // long hold-off on request so that final bytes back up behind a full output register.
  initial begin : result_sink
    int gap;
    bit parked;
    parked = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (park_out && !parked) begin
        out_chan.ready <= 1'b0;
        repeat (PARK_CYCLES) @(posedge clk);
        parked = 1'b1;
      end
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid === 1'b1 && out_chan.ready === 1'b1));
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] ip, input logic [15:0] lo,
                            input logic [15:0] hi);
    write_reg(REG_LOCAL_IP, ip);
    write_reg(REG_PORT_LOW, {16'h0, lo});
    write_reg(REG_PORT_HIGH, {16'h0, hi});
    cur_ip   = ip;
    cur_low  = lo;
    cur_high = hi;
  endtask

  function automatic void put_byte(input int idx, input logic [7:0] v);
    if (idx < frame_buf.size()) frame_buf[idx] = v;
  endfunction

  task automatic start_frame(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
  endtask

  task automatic fill_frame(input int len, input logic [7:0] v);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(v);
  endtask

  // Fields are laid down in wire order; with a short header the TCP fields
  // overwrite whatever IPv4 bytes they overlap.
  task automatic compose_reply(input logic [15:0] etype, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [31:0] dst,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input logic [7:0] flags, input int len);
    logic [31:0] src;
    int          tcp_at;
    src = $urandom;
    tcp_at = int'(ETH_LEN) + 4 * int'(ihl);
    start_frame(len);
    put_byte(POS_ETYPE_HI, etype[15:8]);
    put_byte(POS_ETYPE_LO, etype[7:0]);
    put_byte(POS_IHL, {4'h4, ihl});
    put_byte(POS_PROTO, proto);
    for (int i = 0; i < 4; i++) begin
      put_byte(POS_SRC_FIRST + i, src[31 - 8 * i -: 8]);
      put_byte(POS_DST_FIRST + i, dst[31 - 8 * i -: 8]);
    end
    put_byte(tcp_at + TCP_SPORT_HI, sport[15:8]);
    put_byte(tcp_at + TCP_SPORT_LO, sport[7:0]);
    put_byte(tcp_at + TCP_DPORT_HI, dport[15:8]);
    put_byte(tcp_at + TCP_DPORT_LO, dport[7:0]);
    put_byte(tcp_at + TCP_FLAGS, flags);
  endtask

  task automatic send_frame();
    int gap;
    for (int i = 0; i < frame_buf.size(); i++) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_chan.frame_byte <= frame_buf[i];
      in_chan.last_byte  <= (i == frame_buf.size() - 1);
      in_chan.valid      <= 1'b1;
      do @(posedge clk); while (in_chan.ready !== 1'b1);
      bytes_sent++;
    end
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_frame();
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] dst;
    logic [15:0] dport;
    logic [7:0]  flags;
    int          need;
    int          len;
    int          pick;
    if ($urandom_range(0, 99) < 20) begin
      start_frame($urandom_range(1, 40));
    end else begin
      pick  = $urandom_range(0, 19);
      etype = (pick != 0) ? ETHERTYPE_IPV4 : 16'($urandom);
      pick  = $urandom_range(0, 19);
      proto = (pick != 0) ? PROTO_TCP : 8'($urandom);
      ihl   = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom);
      dst   = ($urandom_range(0, 19) < 17) ? cur_ip : cur_ip ^ (32'd1 << $urandom_range(0, 31));

      case ($urandom_range(0, 9))
        0: dport = cur_low - 16'd1;
        1: dport = cur_high + 16'd1;
        2: dport = cur_low;
        3: dport = cur_high;
        4: dport = 16'($urandom);
        default: dport = (cur_low <= cur_high) ? 16'($urandom_range(cur_high, cur_low))
                                               : 16'($urandom);
      endcase

      flags = 8'($urandom);
      case ($urandom_range(0, 3))
        0: flags = flags | FL_RST;
        1: flags = (flags & ~FL_RST) | FL_SYN | FL_ACK;
        2: flags = flags | FL_SYN | FL_ACK;
        default: ;
      endcase

      need = int'(ETH_LEN) + 4 * int'(ihl) + int'(TCP_LEN);
      if (need < int'(MIN_FRAME_LEN)) need = MIN_FRAME_LEN;
      pick = $urandom_range(0, 19);
      if (pick < 13) len = need + $urandom_range(0, 12);
      else if (pick < 16) len = need - $urandom_range(1, 6);
      else if (pick < 18) len = $urandom_range(need, 150);
      else len = $urandom_range(1, int'(MIN_FRAME_LEN) - 1);
      compose_reply(etype, ihl, proto, dst, 16'($urandom), dport, flags, len);
    end
    send_frame();
  endtask

  initial begin : stimulus
    int phase;
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.frame_byte <= '0;
    in_chan.last_byte  <= 1'b0;
    cur_ip      = 32'h0;
    cur_low     = 16'h0;
    cur_high    = 16'hFFFF;
    bytes_sent  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at their reset values: address zero, full port range.
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'h0, 16'h1234, 16'hFFFF,
                  FL_SYN | FL_ACK, 54);
    send_frame();
    wait_idle();
    set_config(32'hC0A8_0001, 16'h0400, 16'h8000);

    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0050, 16'h1F90,
                  FL_SYN | FL_ACK, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h01BB, 16'h2000,
                  FL_RST | FL_ACK, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'hFFFF, 16'h2000,
                  FL_RST | FL_SYN | FL_ACK, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0016, 16'h2000, FL_SYN, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0000, 16'h2000, FL_ACK, 54);
    send_frame();
    compose_reply(16'h86DD, 4'd5, PROTO_TCP, cur_ip, 16'h0050, 16'h2000,
                  FL_SYN | FL_ACK, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, cur_ip, 16'h0050, 16'h2000,
                  FL_SYN | FL_ACK, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip ^ 32'h1, 16'h0050, 16'h2000,
                  FL_SYN | FL_ACK, 54);
    send_frame();
    // Port range edges: one below and on the low bound, on and one above the high bound.
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0050, 16'h03FF, FL_RST, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0050, 16'h0400, FL_RST, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0050, 16'h8000, FL_RST, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0050, 16'h8001, FL_RST, 54);
    send_frame();
    // Short frames: one byte below the minimum, and one byte short of a
    // maximum-length header plus TCP header.
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0050, 16'h2000,
                  FL_SYN | FL_ACK, 53);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd15, PROTO_TCP, cur_ip, 16'h0050, 16'h2000,
                  FL_SYN | FL_ACK, 93);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd15, PROTO_TCP, cur_ip, 16'h0050, 16'h2000,
                  FL_SYN | FL_ACK, 94);
    send_frame();
    // Header length zero: the source port's high byte doubles as the length.
    compose_reply(ETHERTYPE_IPV4, 4'd0, PROTO_TCP, cur_ip, 16'h40A0, 16'h2000,
                  FL_SYN | FL_ACK, 54);
    send_frame();
    compose_reply(ETHERTYPE_IPV4, 4'd3, PROTO_TCP, cur_ip, 16'h0050, 16'h2000,
                  FL_RST, 54);
    send_frame();
    // Long frame, past the point where the byte counter saturates.
    compose_reply(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, cur_ip, 16'h0050, 16'h2000,
                  FL_SYN | FL_ACK, 140);
    send_frame();
    fill_frame(1, 8'hA5);
    send_frame();
    fill_frame(20, 8'h00);
    send_frame();
    fill_frame(20, 8'hFF);
    send_frame();

    phase = 0;
    while (phase < PHASE_COUNT || bytes_sent < TARGET_BYTES) begin
      wait_idle();
      case (phase % PHASE_COUNT)
        0: set_config($urandom, 16'h0000, 16'hFFFF);
        1: set_config(32'hFFFF_FFFF, 16'($urandom), 16'h0);
        2: set_config(32'h0, 16'h0000, 16'h0000);
        3: set_config($urandom, 16'hFFFF, 16'hFFFF);
        4: set_config($urandom, 16'h9000, 16'h1000);
        default: set_config($urandom, 16'($urandom_range(0, 32767)),
                            16'($urandom_range(32768, 65535)));
      endcase
      if (phase % PHASE_COUNT == 1) cur_high = cur_low;
      if (phase % PHASE_COUNT == 1) write_reg(REG_PORT_HIGH, {16'h0, cur_high});
      steady = (phase % 3 == 2);
      if (phase == 2) begin
        park_out = 1'b1;
        repeat (4) begin
          start_frame($urandom_range(2, 20));
          send_frame();
        end
      end
      random_frame();
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/trc_pkg.sv
rtl/core/trc_in_if.sv
rtl/core/trc_out_if.sv
rtl/core/trc_cfg_regs.sv
rtl/core/trc_hdr_capture.sv
rtl/core/trc_classify.sv
rtl/core/tcp_response_classifier_core.sv
verif/tcp_classifier_checker.sv
verif/tb_top.sv
